@@ rtl/assert_macros.svh @@
// Assertion macros used by bfloat16_add_sub_unit.
// The macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with a label, a property and a message.
`define BF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

@@ rtl/bf16as_pkg.sv @@
// Package for the bfloat16 add/subtract unit: widths and stage record types.
// No dependencies.
`default_nettype none
package bf16as_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned ManW  = 7;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               zero;
    logic [ExpW-1:0]    exp;
    logic signed [ManW+1:0] xv;
    logic signed [ManW+1:0] yv;
  } align_t;

  typedef struct packed {
    logic            zero;
    logic            sign;
    logic [ExpW-1:0] exp;
    logic [ManW+1:0] mag;
  } sum_t;

endpackage
`default_nettype wire

@@ rtl/bfloat16_add_sub_unit.sv @@
// Top level of the truncating bfloat16 add/subtract unit, three register stages.
// Depends on bf16as_pkg, bf16as_align, bf16as_add, bf16as_norm, assert_macros.svh.
//
//   channel | handshake              | payload
//   input   | in_valid_i/in_ready_o  | cmd_i, operand_a_i, operand_b_i
//   output  | out_valid_o/out_ready_i| sum_bits_o
//
// One item enters per cycle while in_ready_o is high. An accepted item moves
// through align_q, sum_q and res_q; out_valid_o is high while it sits in
// res_q. The pipeline advances as a whole whenever the output register is
// empty or being taken, so a stall on the output freezes every stage.
// Reset clears only the stage valid bits.
`default_nettype none
`include "assert_macros.svh"
module bfloat16_add_sub_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] operand_a_i,
  input  wire logic [15:0] operand_b_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      sum_bits_o
);

  bf16as_pkg::align_t align_d, align_q;
  bf16as_pkg::sum_t   sum_d, sum_q;
  logic [15:0]        res_d, res_q;
  logic               v1_q, v2_q, v3_q;
  logic               adv;

  assign adv        = !v3_q || out_ready_i;
  assign in_ready_o = adv;

  bf16as_align u_align (
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .align_o     (align_d)
  );

  bf16as_add u_add (
    .align_i (align_q),
    .sum_o   (sum_d)
  );

  bf16as_norm u_norm (
    .sum_i      (sum_q),
    .sum_bits_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      align_q <= align_d;
      sum_q   <= sum_d;
      res_q   <= res_d;
    end
  end

  assign out_valid_o = v3_q;
  assign sum_bits_o  = res_q;

  `BF_ASSERT(a_s1_moves, v1_q && adv |=> v2_q, "stage one item lost")
  `BF_ASSERT(a_s2_moves, v2_q && adv |=> v3_q, "stage two item lost")
  `BF_ASSERT(a_freeze, !adv |=> (v1_q == $past(v1_q)) && (v2_q == $past(v2_q)),
             "pipeline moved while stalled")

endmodule
`default_nettype wire

@@ rtl/bf16as_align.sv @@
// Operand preparation and exponent alignment for the bfloat16 add/subtract unit.
// Depends on bf16as_pkg.
`default_nettype none
module bf16as_align (
  input  wire logic                          cmd_i,
  input  wire logic [bf16as_pkg::WordW-1:0]  operand_a_i,
  input  wire logic [bf16as_pkg::WordW-1:0]  operand_b_i,
  output bf16as_pkg::align_t                 align_o
);

  logic [bf16as_pkg::WordW-1:0] neg_b, y, neg_y;
  logic [bf16as_pkg::ExpW-1:0]  xe, ye, diff;
  logic signed [bf16as_pkg::ManW+1:0] xs, ys;
  logic [3:0] sh;

  always_comb begin
    neg_b = (operand_b_i == '0) ? '0 : (operand_b_i ^ 16'h8000);
    y     = (bf16as_pkg::cmd_e'(cmd_i) == bf16as_pkg::CMD_SUB) ? neg_b : operand_b_i;
    neg_y = (y == '0) ? '0 : (y ^ 16'h8000);

    xs = operand_a_i[15] ? -$signed({2'b01, operand_a_i[6:0]})
                         : $signed({2'b01, operand_a_i[6:0]});
    ys = y[15] ? -$signed({2'b01, y[6:0]}) : $signed({2'b01, y[6:0]});

    xe = operand_a_i[14:7];
    ye = y[14:7];
    diff = (xe > ye) ? (xe - ye) : (ye - xe);
    sh = (|diff[7:4]) ? 4'hF : diff[3:0];

    align_o.zero = ((bf16as_pkg::cmd_e'(cmd_i) == bf16as_pkg::CMD_SUB) &&
                    (operand_a_i == operand_b_i)) ||
                   ((operand_a_i == '0) && (y == '0)) ||
                   (operand_a_i == neg_y);
    if (xe > ye) begin
      align_o.exp = xe;
      align_o.xv  = xs;
      align_o.yv  = ys >>> sh;
    end else begin
      align_o.exp = ye;
      align_o.xv  = xs >>> sh;
      align_o.yv  = ys;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bf16as_add.sv @@
// Significand addition and sign/magnitude conversion.
// Depends on bf16as_pkg.
`default_nettype none
module bf16as_add (
  input  wire bf16as_pkg::align_t align_i,
  output bf16as_pkg::sum_t        sum_o
);

  logic signed [bf16as_pkg::ManW+2:0] total;
  logic [bf16as_pkg::ManW+2:0]        mag;

  always_comb begin
    total = {align_i.xv[bf16as_pkg::ManW+1], align_i.xv} +
            {align_i.yv[bf16as_pkg::ManW+1], align_i.yv};
    mag   = total[bf16as_pkg::ManW+2] ? (~total + 1'b1) : total;
    sum_o.zero = align_i.zero;
    sum_o.sign = total[bf16as_pkg::ManW+2];
    sum_o.exp  = align_i.exp;
    sum_o.mag  = mag[bf16as_pkg::ManW+1:0];
  end

endmodule
`default_nettype wire

@@ rtl/bf16as_norm.sv @@
// Leading-one normalization and result packing, truncating.
// Depends on bf16as_pkg.
`default_nettype none
module bf16as_norm (
  input  wire bf16as_pkg::sum_t             sum_i,
  output logic [bf16as_pkg::WordW-1:0]      sum_bits_o
);

  logic [3:0]                    lsh;
  logic [bf16as_pkg::ManW:0]     shifted;
  logic [bf16as_pkg::ExpW:0]     e9;

  always_comb begin
    lsh = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (sum_i.mag[i]) begin
        lsh = 4'(7 - i);
      end
    end
    if (sum_i.mag[8]) begin
      shifted = sum_i.mag[8:1];
      e9      = {1'b0, sum_i.exp} + 9'd1;
    end else begin
      shifted = sum_i.mag[7:0] << lsh;
      e9      = {1'b0, sum_i.exp} - {5'b0, lsh};
    end
    if (sum_i.zero) begin
      sum_bits_o = '0;
    end else begin
      sum_bits_o = {sum_i.sign, 15'b0} + {e9, shifted[bf16as_pkg::ManW-1:0]};
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/bfloat16_add_sub_unit_checker.sv @@
// Checker for the bfloat16 add/subtract unit: watches both channels, predicts
// each sum from the accepted operands and compares it. Depends on bf16as_pkg.
`timescale 1ns / 100ps
module bfloat16_add_sub_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] sum_bits_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] sum_q[$];

  function automatic logic [15:0] flip_sign(logic [15:0] x);
    if (x == 16'h0000) return 16'h0000;
    return x ^ 16'h8000;
  endfunction

  function automatic int signif(logic [15:0] x);
    int m;
    m = int'({1'b1, x[bf16as_pkg::ManW-1:0]});
    return x[15] ? -m : m;
  endfunction

  function automatic int shift_sat(int v, int s);
    if (s > 16) s = 16;
    return v >>> s;
  endfunction

  function automatic logic [15:0] bf16_sum(logic [15:0] x, logic [15:0] y);
    int xv, yv, s, lead, e, mw;
    int unsigned mag;
    logic sgn;
    int unsigned word;
    mw = int'(bf16as_pkg::ManW);
    if (x == 16'h0000 && y == 16'h0000) return 16'h0000;
    if (x == flip_sign(y)) return 16'h0000;
    xv = signif(x);
    yv = signif(y);
    if (x[14:7] > y[14:7]) begin
      yv = shift_sat(yv, int'(x[14:7]) - int'(y[14:7]));
      e = x[14:7];
    end else begin
      xv = shift_sat(xv, int'(y[14:7]) - int'(x[14:7]));
      e = y[14:7];
    end
    s = xv + yv;
    sgn = s < 0;
    mag = sgn ? -s : s;
    lead = -1;
    for (int p = 15; p >= 0; p--) begin
      if (lead < 0 && mag[p]) lead = p;
    end
    if (lead > mw) begin
      mag = mag >> (lead - mw);
      e = e + lead - mw;
    end else if (lead < mw) begin
      mag = mag << (mw - lead);
      e = e - (mw - lead);
    end
    word = (int'(sgn) << 15) + (e << mw) + (mag & 32'h7F);
    return word[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = sum_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        if (bf16as_pkg::cmd_e'(cmd_i) == bf16as_pkg::CMD_SUB) begin
          sum_q.push_back(operand_a_i == operand_b_i ? 16'h0000
                          : bf16_sum(operand_a_i, flip_sign(operand_b_i)));
        end else begin
          sum_q.push_back(bf16_sum(operand_a_i, operand_b_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (sum_q.size() == 0) report_mismatch("unexpected item", sum_bits_i, 16'h0);
        else begin
          logic [15:0] want;
          want = sum_q.pop_front();
          if (sum_bits_i !== want) report_mismatch("sum_bits", sum_bits_i, want);
        end
      end
    end
  end

endmodule

@@ tb/sv/bfloat16_add_sub_unit_tb.sv @@
// Top of the bfloat16 add/subtract unit testbench: clock, reset, stimulus and
// verdict. Depends on bf16as_pkg, the unit and bfloat16_add_sub_unit_checker.
`timescale 1ns / 100ps
module bfloat16_add_sub_unit_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [15:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] sum_bits_o;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          hold_off = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bfloat16_add_sub_unit u_dut (.*);

  bfloat16_add_sub_unit_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .operand_a_i,
    .operand_b_i, .out_valid_i(out_valid_o), .out_ready_i, .sum_bits_i(sum_bits_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_operand(logic [15:0] other);
    case ($urandom_range(0, 7))
      0: return other;
      1: return other ^ 16'h8000;
      2: return {other[15:7] + 9'($urandom_range(0, 3)), 7'($urandom)};
      3: return {1'($urandom), other[14:7] - 8'($urandom_range(0, 20)), 7'($urandom)};
      4: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(bf16as_pkg::cmd_e c, logic [15:0] a, logic [15:0] b);
    int g;
    g = gap_len();
    if (g != 0) in_valid_i <= 1'b0;
    repeat (g) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("bfloat16_add_sub_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int g;
    wait (rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      out_ready_i <= (g == 0);
      repeat (g == 0 ? $urandom_range(1, 6) : g) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [15:0] a, b;
    logic [15:0] edge_vals[8] = '{16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF,
                                  16'h3F80, 16'hBF80, 16'h0080, 16'h7F00};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (edge_vals[i]) begin
      send_item(bf16as_pkg::CMD_ADD, edge_vals[i], edge_vals[(i + 1) % 8]);
      send_item(bf16as_pkg::CMD_SUB, edge_vals[i], edge_vals[(i + 3) % 8]);
    end
    send_item(bf16as_pkg::CMD_SUB, 16'h4000, 16'h4000);
    send_item(bf16as_pkg::CMD_ADD, 16'h4000, 16'hC000);
    send_item(bf16as_pkg::CMD_ADD, 16'h8000, 16'h0000);
    send_item(bf16as_pkg::CMD_ADD, 16'h7F80, 16'h0080);
    send_item(bf16as_pkg::CMD_ADD, 16'h7FFF, 16'h7FFF);
    send_item(bf16as_pkg::CMD_SUB, 16'h0080, 16'h0000);
    send_item(bf16as_pkg::CMD_ADD, 16'h3F80, 16'h3C00);
    for (int n = 0; n < 600; n++) begin
      if (n == 200) hold_off = 1'b1;
      a = 16'($urandom);
      b = rand_operand(a);
      if ($urandom_range(0, 1)) send_item(bf16as_pkg::CMD_SUB, a, b);
      else send_item(bf16as_pkg::CMD_ADD, b, a);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bfloat16_add_sub_unit_tb: PASS");
    end else begin
      $display("bfloat16_add_sub_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bf16as_pkg.sv
rtl/bf16as_align.sv
rtl/bf16as_add.sv
rtl/bf16as_norm.sv
rtl/bfloat16_add_sub_unit.sv
tb/sv/bfloat16_add_sub_unit_checker.sv
tb/sv/bfloat16_add_sub_unit_tb.sv
